@@ hdl/scfc_pkg.sv @@
// scfc_pkg: shared types, constants and the CRC-8 byte function for the
// sensor frame decoder. No dependencies.
`timescale 1ns / 1ps

package scfc_pkg;

    // Frame layout and checksum constants
    localparam int          FRAME_BYTES = 6;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;

    // Conversion constants: T = (175*raw - 45*2^16) / 2^16, RH = 100*raw / 2^16
    localparam logic [7:0]  TEMP_SCALE  = 8'd175;
    localparam int          TEMP_OFFSET = 45 * (1 << 16);
    localparam logic [6:0]  HUM_SCALE   = 7'd100;

    // Position of a byte within the frame, in wire order
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } t_byte_pos;

    // Completed frame handed from the parser to the converter
    typedef struct packed {
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        logic        temp_ok;
        logic        hum_ok;
    } t_frame;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hdl/scfc_parser.sv @@
// scfc_parser: tracks byte position, runs the CRC-8 over each word and
// holds a completed frame until the converter takes it. Uses scfc_pkg.
`timescale 1ns / 1ps

module scfc_parser
    import scfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    input  logic       i_out_ready,
    output logic       o_frame_valid,
    output t_frame     o_frame
);

    t_byte_pos   r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_raw_t, n_raw_t;
    logic [7:0]  r_hum_hi, n_hum_hi;
    logic [7:0]  r_hum_lo, n_hum_lo;
    logic        r_temp_ok, n_temp_ok;
    logic        r_s1_valid, n_s1_valid;
    t_frame      r_frame, n_frame;

    t_byte_pos   pos_eff;
    logic        load;

    // Effective position: start flag resyncs, unused codes count as byte 0
    always_comb begin
        if (i_frame_start || r_pos > POS_H_CRC) begin
            pos_eff = POS_T_HI;
        end else begin
            pos_eff = r_pos;
        end
    end

    assign load = i_accept && (pos_eff == POS_H_CRC);

    // Per-byte state update
    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_raw_t   = r_raw_t;
        n_hum_hi  = r_hum_hi;
        n_hum_lo  = r_hum_lo;
        n_temp_ok = r_temp_ok;
        n_frame   = r_frame;
        if (i_accept) begin
            n_pos = (pos_eff == POS_H_CRC) ? POS_T_HI : t_byte_pos'(pos_eff + 3'd1);
            case (pos_eff)
                POS_T_HI: begin
                    n_crc   = crc8_byte(CRC_INIT, i_rx_byte);
                    n_raw_t = {i_rx_byte, 8'h00};
                end
                POS_T_LO: begin
                    n_crc   = crc8_byte(r_crc, i_rx_byte);
                    n_raw_t = {r_raw_t[15:8], i_rx_byte};
                end
                POS_T_CRC: begin
                    n_temp_ok = (r_crc == i_rx_byte);
                    n_crc     = CRC_INIT;
                end
                POS_H_HI: begin
                    n_crc    = crc8_byte(CRC_INIT, i_rx_byte);
                    n_hum_hi = i_rx_byte;
                end
                POS_H_LO: begin
                    n_crc    = crc8_byte(r_crc, i_rx_byte);
                    n_hum_lo = i_rx_byte;
                end
                default: begin
                    n_crc           = CRC_INIT;
                    n_frame.raw_t   = r_raw_t;
                    n_frame.raw_h   = {r_hum_hi, r_hum_lo};
                    n_frame.temp_ok = r_temp_ok;
                    n_frame.hum_ok  = (r_crc == i_rx_byte);
                end
            endcase
        end
    end

    // Completed-frame holding stage
    assign n_s1_valid = load || (r_s1_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_T_HI;
            r_crc      <= CRC_INIT;
            r_raw_t    <= '0;
            r_hum_hi   <= '0;
            r_hum_lo   <= '0;
            r_temp_ok  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_raw_t    <= n_raw_t;
            r_hum_hi   <= n_hum_hi;
            r_hum_lo   <= n_hum_lo;
            r_temp_ok  <= n_temp_ok;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    assign o_frame_valid = r_s1_valid;
    assign o_frame       = r_frame;

    // A closing checksum byte always yields a held frame
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_s1_valid)
        else $error("frame not held after final byte");

    // Start flag resyncs: the next byte is the temperature low byte
    a_start_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_frame_start) |=> (r_pos == POS_T_LO))
        else $error("frame start did not resync position");

    // Checksum bytes restart the CRC
    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (pos_eff == POS_T_CRC || pos_eff == POS_H_CRC)) |=> (r_crc == CRC_INIT))
        else $error("CRC not restarted after checksum byte");

endmodule

@@ hdl/scfc_convert.sv @@
// scfc_convert: fixed-point temperature/humidity conversion of a completed
// frame into the result register. Uses scfc_pkg.
`timescale 1ns / 1ps

module scfc_convert
    import scfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s1_valid,
    input  t_frame            i_frame,
    input  logic              i_stall,
    output logic              o_out_ready,
    output logic              o_valid,
    output logic signed [8:0] o_temperature_c,
    output logic [6:0]        o_humidity_pct,
    output logic              o_temp_crc_ok,
    output logic              o_hum_crc_ok,
    output logic              o_frame_valid
);

    logic              r_valid, n_valid;
    logic signed [8:0] r_temp;
    logic [6:0]        r_hum;
    logic              r_temp_ok, r_hum_ok, r_both_ok;

    logic [23:0]        prod_t;
    logic signed [24:0] v_t;
    logic [24:0]        mag_t;
    logic [7:0]         q_t;
    logic signed [8:0]  temp_c;
    logic [22:0]        prod_h;

    // Result register can take a new transaction when empty or draining
    assign o_out_ready = !r_valid || !i_stall;

    // Temperature: signed offset product, truncated toward zero
    always_comb begin
        prod_t = 24'(i_frame.raw_t) * 24'(TEMP_SCALE);
        v_t    = $signed({1'b0, prod_t}) - 25'(TEMP_OFFSET);
        mag_t  = v_t[24] ? 25'(-v_t) : 25'(v_t);
        q_t    = mag_t[23:16];
        temp_c = v_t[24] ? -$signed({1'b0, q_t}) : $signed({1'b0, q_t});
    end

    // Humidity: scaled and shifted down
    assign prod_h = 23'(i_frame.raw_h) * 23'(HUM_SCALE);

    assign n_valid = i_s1_valid || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_valid && o_out_ready) begin
            r_temp    <= temp_c;
            r_hum     <= prod_h[22:16];
            r_temp_ok <= i_frame.temp_ok;
            r_hum_ok  <= i_frame.hum_ok;
            r_both_ok <= i_frame.temp_ok & i_frame.hum_ok;
        end
    end

    assign o_valid         = r_valid;
    assign o_temperature_c = r_temp;
    assign o_humidity_pct  = r_hum;
    assign o_temp_crc_ok   = r_temp_ok;
    assign o_hum_crc_ok    = r_hum_ok;
    assign o_frame_valid   = r_both_ok;

    // Converted temperature stays within the sensor's span
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_temp >= -9'sd45 && r_temp <= 9'sd129))
        else $error("temperature out of range");

    // Converted humidity never reaches 100 percent
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_hum <= 7'd99))
        else $error("humidity out of range");

    // A delivered result with nothing behind it leaves the register empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_stall && !i_s1_valid) |=> !r_valid)
        else $error("result repeated after delivery");

endmodule

@@ hdl/sensor_frame_crc_convert.sv @@
// sensor_frame_crc_convert: top level of the sensor frame decoder.
// Instantiates scfc_parser and scfc_convert; uses scfc_pkg.
//
//   Channel  Direction  Handshake          Payload
//   input    in         i_valid / o_stall  i_rx_byte, i_frame_start
//   output   out        o_valid / i_stall  o_temperature_c, o_humidity_pct,
//                                          o_temp_crc_ok, o_hum_crc_ok, o_frame_valid
//
// One byte is taken per cycle while o_stall is low; CRC and position update on each byte.
// The sixth byte of a frame gives a result through the holding stage,
// then the conversion multiply into the result register.
// Synchronous active-low reset clears position, CRC (to 0xFF) and valid flags.
// o_stall rises only when a completed frame waits behind a stalled result;
// the held frame plus result register let one full frame move behind a stall.
`timescale 1ns / 1ps

module sensor_frame_crc_convert
    import scfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_frame_start,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [8:0] o_temperature_c,
    output logic [6:0]        o_humidity_pct,
    output logic              o_temp_crc_ok,
    output logic              o_hum_crc_ok,
    output logic              o_frame_valid
);

    logic   s1_valid;
    logic   out_ready;
    logic   accept;
    t_frame frame;

    // Stall input only while a finished frame cannot move forward
    assign o_stall = s1_valid && !out_ready;
    assign accept  = i_valid && !o_stall;

    scfc_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_out_ready   (out_ready),
        .o_frame_valid (s1_valid),
        .o_frame       (frame)
    );

    scfc_convert u_convert (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s1_valid      (s1_valid),
        .i_frame         (frame),
        .i_stall         (i_stall),
        .o_out_ready     (out_ready),
        .o_valid         (o_valid),
        .o_temperature_c (o_temperature_c),
        .o_humidity_pct  (o_humidity_pct),
        .o_temp_crc_ok   (o_temp_crc_ok),
        .o_hum_crc_ok    (o_hum_crc_ok),
        .o_frame_valid   (o_frame_valid)
    );

endmodule

@@ tb/sensor_frame_crc_convert_test.sv @@
// sensor_frame_crc_convert_test: self-checking testbench for the sensor frame decoder.
// It sends frame bytes and predicts CRC flags and converted readings with a scoreboard class.
// Depends on scfc_pkg and sensor_frame_crc_convert.
`timescale 1ns / 1ps

module sensor_frame_crc_convert_test;
    import scfc_pkg::*;

    // One decoded frame as seen on the result port
    typedef struct {
        logic signed [8:0] temp_c;
        logic [6:0]        hum_pct;
        logic              t_ok;
        logic              h_ok;
        logic              both_ok;
    } t_frame_reading;

    // Tracks the frame position, predicts each reading and checks the results in order
    class FrameScoreboard;
        t_frame_reading readings_due[$];
        logic [2:0]     next_pos;
        logic [7:0]     word_crc;
        logic [15:0]    raw_temp;
        logic [7:0]     hum_hi;
        logic [7:0]     hum_lo;
        logic           temp_ok_flag;
        int             errors;
        int             frames_seen;
        int             temp_bad;
        int             hum_bad;
        int             resyncs;

        function new();
            next_pos     = 3'd0;
            word_crc     = CRC_INIT;
            raw_temp     = 16'h0000;
            hum_hi       = 8'h00;
            hum_lo       = 8'h00;
            temp_ok_flag = 1'b0;
            errors       = 0;
            frames_seen  = 0;
            temp_bad     = 0;
            hum_bad      = 0;
            resyncs      = 0;
        endfunction

        // CRC-8 over one byte, one bit per step, MSB first
        static function logic [7:0] crc_update(logic [7:0] crc, logic [7:0] data);
            logic [7:0] r;
            logic       fb;
            r = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = r[7] ^ data[i];
                r  = {r[6:0], 1'b0};
                if (fb) begin
                    r = r ^ CRC_POLY;
                end
            end
            return r;
        endfunction

        task report(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        function int pending();
            return readings_due.size();
        endfunction

        // Accepted input transaction: advance the frame and queue a reading on the last byte
        task note_byte(logic [7:0] b, logic st);
            logic [2:0]     p;
            t_frame_reading r;
            int             t_scaled;
            int             rh;
            logic           h_ok;
            p = next_pos;
            if (st) begin
                if (p != 3'd0) begin
                    resyncs++;
                end
                p = 3'd0;
            end
            if (p >= FRAME_BYTES) begin
                p = 3'd0;
            end
            case (t_byte_pos'(p))
                POS_T_HI: begin
                    word_crc = crc_update(CRC_INIT, b);
                    raw_temp = {b, 8'h00};
                end
                POS_T_LO: begin
                    word_crc = crc_update(word_crc, b);
                    raw_temp = {raw_temp[15:8], b};
                end
                POS_T_CRC: begin
                    temp_ok_flag = (word_crc == b);
                    word_crc     = CRC_INIT;
                end
                POS_H_HI: begin
                    word_crc = crc_update(CRC_INIT, b);
                    hum_hi   = b;
                end
                POS_H_LO: begin
                    word_crc = crc_update(word_crc, b);
                    hum_lo   = b;
                end
                default: begin
                    h_ok     = (word_crc == b);
                    // signed integer division truncates toward zero
                    t_scaled = int'(TEMP_SCALE) * int'(raw_temp) - TEMP_OFFSET;
                    rh       = int'({hum_hi, hum_lo});
                    r.temp_c  = 9'(t_scaled / 65536);
                    r.hum_pct = 7'((int'(HUM_SCALE) * rh) >> 16);
                    r.t_ok    = temp_ok_flag;
                    r.h_ok    = h_ok;
                    r.both_ok = temp_ok_flag & h_ok;
                    readings_due.push_back(r);
                    word_crc = CRC_INIT;
                    frames_seen++;
                    if (!temp_ok_flag) temp_bad++;
                    if (!h_ok) hum_bad++;
                end
            endcase
            p = p + 3'd1;
            if (p >= FRAME_BYTES) begin
                p = 3'd0;
            end
            next_pos = p;
        endtask

        // Accepted output transaction: compare with the oldest prediction
        task check_result(t_frame_reading got);
            t_frame_reading want;
            if (readings_due.size() == 0) begin
                report($sformatf("unexpected result temp=%0d hum=%0d", got.temp_c, got.hum_pct));
                return;
            end
            want = readings_due.pop_front();
            if (got.temp_c !== want.temp_c)
                report($sformatf("temperature got %0d want %0d", got.temp_c, want.temp_c));
            if (got.hum_pct !== want.hum_pct)
                report($sformatf("humidity got %0d want %0d", got.hum_pct, want.hum_pct));
            if (got.t_ok !== want.t_ok)
                report($sformatf("temp_crc_ok got %b want %b", got.t_ok, want.t_ok));
            if (got.h_ok !== want.h_ok)
                report($sformatf("hum_crc_ok got %b want %b", got.h_ok, want.h_ok));
            if (got.both_ok !== want.both_ok)
                report($sformatf("frame_valid got %b want %b", got.both_ok, want.both_ok));
        endtask
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [7:0]        i_rx_byte     = 8'h00;
    logic              i_frame_start = 1'b0;
    logic              i_stall       = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic signed [8:0] o_temperature_c;
    logic [6:0]        o_humidity_pct;
    logic              o_temp_crc_ok;
    logic              o_hum_crc_ok;
    logic              o_frame_valid;

    FrameScoreboard sb = new();
    t_frame_reading seen_reading;
    bit             send_gaps_on  = 1'b1;
    bit             stall_on      = 1'b1;
    int             bytes_sent    = 0;

    sensor_frame_crc_convert DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_start  (i_frame_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_temperature_c(o_temperature_c),
        .o_humidity_pct (o_humidity_pct),
        .o_temp_crc_ok  (o_temp_crc_ok),
        .o_hum_crc_ok   (o_hum_crc_ok),
        .o_frame_valid  (o_frame_valid)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result monitor and random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_reading.temp_c  = o_temperature_c;
            seen_reading.hum_pct = o_humidity_pct;
            seen_reading.t_ok    = o_temp_crc_ok;
            seen_reading.h_ok    = o_hum_crc_ok;
            seen_reading.both_ok = o_frame_valid;
            sb.check_result(seen_reading);
        end
        i_stall <= stall_on && ($urandom_range(99) < 31);
    end

    // Send one byte; called and returns at a rising edge
    task send_byte(input logic [7:0] b, input logic st);
        while (send_gaps_on && ($urandom_range(99) < 31)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= st;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b, st);
        bytes_sent++;
    endtask

    // Send the first n_bytes of a frame, with good or corrupted checksums
    task send_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                    input bit t_good, input bit h_good, input bit st, input int n_bytes);
        logic [7:0] frame_bytes[6];
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = FrameScoreboard::crc_update(FrameScoreboard::crc_update(CRC_INIT, raw_t[15:8]),
                                            raw_t[7:0]);
        h_crc = FrameScoreboard::crc_update(FrameScoreboard::crc_update(CRC_INIT, raw_h[15:8]),
                                            raw_h[7:0]);
        if (!t_good) t_crc = t_crc ^ 8'($urandom_range(255, 1));
        if (!h_good) h_crc = h_crc ^ 8'($urandom_range(255, 1));
        frame_bytes = '{raw_t[15:8], raw_t[7:0], t_crc, raw_h[15:8], raw_h[7:0], h_crc};
        for (int k = 0; k < n_bytes; k++) begin
            send_byte(frame_bytes[k], (k == 0) ? st : 1'b0);
        end
    endtask

    function logic [15:0] pick_raw();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(16852 + $urandom_range(3) - 2);  // near zero degrees
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Main stimulus
    initial begin
        int choice;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, missing start, resync, checksum failures
        send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 6);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b0, 6);
        send_frame(16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1, 2);
        send_frame(16'd16852, 16'h8000, 1'b1, 1'b0, 1'b1, 6);
        send_frame(16'd16477, 16'hA5C3, 1'b0, 1'b0, 1'b1, 6);
        i_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);

        // Random: mostly well-formed frames, some truncated frames and noise
        while (bytes_sent < 550) begin
            send_gaps_on = !(bytes_sent >= 180 && bytes_sent < 300);
            stall_on     = send_gaps_on;
            if (bytes_sent >= 380 && bytes_sent < 386) begin
                i_valid <= 1'b0;
                wait_drained();
                @(posedge i_clk);
            end
            choice = $urandom_range(99);
            if (choice < 75) begin
                send_frame(pick_raw(), pick_raw(), $urandom_range(99) < 85,
                           $urandom_range(99) < 85, $urandom_range(99) < 80, 6);
            end else if (choice < 88) begin
                send_frame(pick_raw(), pick_raw(), 1'b1, 1'b1, 1'($urandom_range(1)),
                           $urandom_range(5, 1));
            end else begin
                repeat ($urandom_range(4, 1))
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        while (sb.pending() != 0) begin
            void'(sb.readings_due.pop_front());
            sb.report("expected result never arrived");
        end
        $display("%0d bytes sent, %0d frames decoded", bytes_sent, sb.frames_seen);
        $display("%0d bad temperature CRC, %0d bad humidity CRC, %0d mid-frame resyncs",
                 sb.temp_bad, sb.hum_bad, sb.resyncs);
        $display("%0d mismatches", sb.errors);
        if (sb.errors == 0) begin
            $display("sensor_frame_crc_convert regression: pass");
        end else begin
            $display("sensor_frame_crc_convert regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("timeout waiting for results");
        $display("sensor_frame_crc_convert regression: fail");
        $finish;
    end

endmodule
